// ===== rtl/core/mavw_pkg.sv =====
`default_nettype none
package mavw_pkg;

    localparam int WINDOW_DEFAULT      = 16;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_DIV,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic accept;
        logic acc;
        logic div_step;
        logic load_out;
    } t_cmd;

endpackage
`default_nettype wire

// ===== rtl/core/moving_average_window.sv =====
// Moving average over the last WINDOW signed samples. Each input transfer pushes one
// sample into a ring buffer and yields one result transfer carrying the mean of the
// stored samples (truncated toward zero) and the number of samples held, which rises to
// WINDOW and then stays there. An item passes from the input transfer through the sum
// update and the bit-serial divider, which produces one quotient bit per cycle, to the
// load into the output register, which waits until that register is free; the next
// sample can be taken in the cycle after the result is loaded. The output register
// lets a new sample be taken while the previous result still waits for its transfer.
`default_nettype none
module moving_average_window
    import mavw_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEFAULT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
    localparam int CNT_W      = $clog2(WINDOW + 1),
    localparam int SUM_W      = SAMPLE_BITS + $clog2(WINDOW)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_sample_valid,
    output logic                        o_sample_ready,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    output logic                        o_result_valid,
    input  wire logic                   i_result_ready,
    output logic      [SAMPLE_BITS-1:0] o_average,
    output logic      [CNT_W-1:0]       o_fill_count
);

    t_cmd cmd;

    mavw_ctrl #(
        .STEPS (SUM_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_cmd          (cmd)
    );

    mavw_dpath #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_sample     (i_sample),
        .o_average    (o_average),
        .o_fill_count (o_fill_count)
    );

endmodule
`default_nettype wire

// ===== rtl/core/mavw_ram.sv =====
`default_nettype none
module mavw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/mavw_ctrl.sv =====
`default_nettype none
module mavw_ctrl
    import mavw_pkg::*;
#(
    parameter int STEPS = 20
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_sample_valid,
    output logic      o_sample_ready,
    output logic      o_result_valid,
    input  wire logic i_result_ready,
    output t_cmd      o_cmd
);

    localparam int STEP_W = $clog2(STEPS);

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              out_free;

    assign out_free = !r_out_valid || i_result_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_sample_valid) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_step == STEP_W'(STEPS - 1)) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_sample_ready = 1'b0;
        n_step         = r_step;
        case (r_state)
            S_IDLE: begin
                o_sample_ready = 1'b1;
                o_cmd.accept   = i_sample_valid;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_step    = '0;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
            end
            S_LOAD: begin
                o_cmd.load_out = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_result_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_result_valid = r_out_valid;

    a_accept_to_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample_valid && o_sample_ready) |=> (r_state == S_ACC))
        else $error("accepted transfer did not start the sum update");

    a_acc_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |=> (r_state == S_DIV && r_step == '0))
        else $error("divider did not start from step zero");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> (o_result_valid && r_state == S_IDLE))
        else $error("loaded result not presented");

endmodule
`default_nettype wire

// ===== rtl/core/mavw_dpath.sv =====
`default_nettype none
module mavw_dpath
    import mavw_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEFAULT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
    localparam int POS_W      = $clog2(WINDOW),
    localparam int CNT_W      = $clog2(WINDOW + 1),
    localparam int SUM_W      = SAMPLE_BITS + POS_W
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cmd                   i_cmd,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    output logic      [SAMPLE_BITS-1:0] o_average,
    output logic      [CNT_W-1:0]       o_fill_count
);

    logic        [SAMPLE_BITS-1:0] r_sample;
    logic        [SAMPLE_BITS-1:0] ram_rd_data;
    logic        [POS_W-1:0]       r_pos;
    logic        [POS_W-1:0]       n_pos;
    logic        [CNT_W-1:0]       r_count;
    logic        [CNT_W-1:0]       n_count;
    logic signed [SUM_W-1:0]       r_sum;
    logic signed [SUM_W-1:0]       n_sum;
    logic signed [SUM_W-1:0]       sample_ext;
    logic signed [SUM_W-1:0]       old_ext;
    logic        [SUM_W-1:0]       sum_mag;
    logic                          full;
    logic        [SUM_W-1:0]       r_quo;
    logic        [CNT_W-1:0]       r_rem;
    logic                          r_neg;
    logic        [CNT_W:0]         trial;
    logic        [CNT_W:0]         trial_diff;
    logic                          q_bit;
    logic        [SUM_W-1:0]       quo_signed;

    mavw_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.acc),
        .i_wr_addr (r_pos),
        .i_wr_data (r_sample),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (r_pos),
        .o_rd_data (ram_rd_data)
    );

    assign full       = (r_count == CNT_W'(WINDOW));
    assign sample_ext = {{(SUM_W - SAMPLE_BITS){r_sample[SAMPLE_BITS-1]}}, r_sample};
    assign old_ext    = full ? {{(SUM_W - SAMPLE_BITS){ram_rd_data[SAMPLE_BITS-1]}}, ram_rd_data}
                             : '0;
    assign n_sum      = r_sum - old_ext + sample_ext;
    assign sum_mag    = n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);
    assign n_count    = full ? r_count : r_count + 1'b1;
    assign n_pos      = (r_pos == POS_W'(WINDOW - 1)) ? '0 : r_pos + 1'b1;

    // One restoring division step per cycle, quotient bits shift in at the bottom.
    assign trial      = {r_rem, r_quo[SUM_W-1]};
    assign trial_diff = trial - {1'b0, r_count};
    assign q_bit      = (trial >= {1'b0, r_count});
    assign quo_signed = r_neg ? (~r_quo + 1'b1) : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_cmd.acc) begin
            r_pos   <= n_pos;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
        end
        if (i_cmd.acc) begin
            r_quo <= sum_mag;
            r_rem <= '0;
            r_neg <= n_sum[SUM_W-1];
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], q_bit};
            r_rem <= q_bit ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
        if (i_cmd.load_out) begin
            o_average    <= quo_signed[SAMPLE_BITS-1:0];
            o_fill_count <= r_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(WINDOW))
        else $error("fill count beyond window");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.acc |=> (r_count != '0))
        else $error("divisor is zero after a sample");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_count))
        else $error("division remainder not below divisor");

endmodule
`default_nettype wire
